// ===== src/xorshift_modulo_draw_macros.svh =====
// Assertion macros used by the generator's core module.
`ifndef XORSHIFT_MODULO_DRAW_MACROS_SVH
`define XORSHIFT_MODULO_DRAW_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while rst is high.
`define XMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst is high.
`define XMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/xmd_pkg.sv =====
// Package with the generator's constants, types and the xorshift step.
`default_nettype none
package xmd_pkg;

  localparam int WORD_W   = 64;
  localparam int VALUE_W  = 63;
  localparam int ALU_W    = WORD_W + 1;
  localparam int CNT_W    = 6;
  localparam int MUL_BITS = 32;
  localparam int DIV_BITS = WORD_W;

  localparam logic [WORD_W-1:0]   SEED_A      = 64'd123456789;
  localparam logic [WORD_W-1:0]   SEED_B      = 64'd362436069;
  localparam logic [WORD_W-1:0]   SEED_C      = 64'd521288629;
  localparam logic [MUL_BITS-1:0] MIX_MUL     = 32'd2654435761;
  localparam logic [WORD_W-1:0]   MIX_ADD     = 64'h0000_0000_9e37_79b9;
  localparam logic [VALUE_W-1:0]  MOD_RESET   = 63'h0000_0001_0000_0000;
  localparam int                  SHIFT_FIRST  = 16;
  localparam int                  SHIFT_SECOND = 5;
  localparam int                  SHIFT_THIRD  = 1;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_BITS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_BITS - 1);

  typedef enum logic {
    OP_DRAW   = 1'b0,
    OP_RESEED = 1'b1
  } xmd_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_DONE
  } xmd_state_t;

  // One request to the shared adder/subtractor.
  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  // Scrambles the first word with the three shift/XOR steps.
  function automatic logic [WORD_W-1:0] scramble(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] v;
    v = w;
    v = v ^ (v << SHIFT_FIRST);
    v = v ^ (v >> SHIFT_SECOND);
    v = v ^ (v << SHIFT_THIRD);
    return v;
  endfunction

  // A state word may never be zero after a reseed.
  function automatic logic [WORD_W-1:0] nonzero(input logic [WORD_W-1:0] w);
    return (w == '0) ? WORD_W'(1) : w;
  endfunction

endpackage
`default_nettype wire

// ===== src/xmd_req_if.sv =====
// Request channel: operation and seed.
`default_nettype none
interface xmd_req_if
  import xmd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [WORD_W-1:0] seed_value;

  modport source (output valid, output operation, output seed_value, input ready);
  modport sink   (input valid, input operation, input seed_value, output ready);
endinterface
`default_nettype wire

// ===== src/xmd_rsp_if.sv =====
// Result channel: the drawn value.
`default_nettype none
interface xmd_rsp_if
  import xmd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface
`default_nettype wire

// ===== src/xmd_cfg_if.sv =====
// Configuration write channel: the modulus register.
`default_nettype none
interface xmd_cfg_if
  import xmd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface
`default_nettype wire

// ===== src/xmd_alu.sv =====
// Shared 65-bit adder/subtractor used by the multiply, add and divide steps.
`default_nettype none
module xmd_alu
  import xmd_pkg::*;
(
  input  alu_req_t         req,
  output logic [ALU_W-1:0] sum
);

  // With sub set the result is a - b; bit 64 set means b was larger.
  assign sum = req.a + (req.sub ? ~req.b : req.b) + ALU_W'(req.sub);

endmodule
`default_nettype wire

// ===== src/xmd_core.sv =====
// Sequencer, state words and shift-add / restoring-divide datapath.
`default_nettype none
`include "xorshift_modulo_draw_macros.svh"
module xmd_core
  import xmd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [VALUE_W-1:0] modulus,
  xmd_req_if.sink            req,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [VALUE_W-1:0] res_value
);

  xmd_state_t state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [WORD_W-1:0]  word_a, word_a_next;
  logic [WORD_W-1:0]  word_b, word_b_next;
  logic [WORD_W-1:0]  word_c, word_c_next;
  logic [WORD_W-1:0]  seed, seed_next;
  logic [WORD_W-1:0]  acc, acc_next;
  logic [WORD_W-1:0]  sh, sh_next;
  logic [WORD_W-1:0]  dvd, dvd_next;
  logic [VALUE_W-1:0] rem, rem_next;
  logic [WORD_W-1:0]  drawn;
  logic [WORD_W-1:0]  trial;
  alu_req_t           alu_req;
  logic [ALU_W-1:0]   alu_sum;
  logic               div_start;
  logic               words_nonzero;
  logic               div_clean;

  xmd_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  assign req.ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res_value = rem;

  // New third word of a draw, from the current words.
  assign drawn = scramble(word_a) ^ word_b ^ word_c;
  assign trial = {rem, dvd[WORD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      word_a <= SEED_A;
      word_b <= SEED_B;
      word_c <= SEED_C;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      word_a <= word_a_next;
      word_b <= word_b_next;
      word_c <= word_c_next;
    end
  end

  always_ff @(posedge clk) begin
    seed <= seed_next;
    acc  <= acc_next;
    sh   <= sh_next;
    dvd  <= dvd_next;
    rem  <= rem_next;
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    word_a_next = word_a;
    word_b_next = word_b;
    word_c_next = word_c;
    seed_next   = seed;
    acc_next    = acc;
    sh_next     = sh;
    dvd_next    = dvd;
    rem_next    = rem;
    alu_req     = '0;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          cnt_next = '0;
          if (req.operation == OP_RESEED) begin
            seed_next  = req.seed_value;
            sh_next    = req.seed_value;
            acc_next   = '0;
            state_next = ST_MUL;
          end else begin
            word_a_next = word_b;
            word_b_next = word_c;
            word_c_next = drawn;
            dvd_next    = drawn;
            if (modulus == '0) begin
              // A zero divisor never subtracts: the word passes through.
              rem_next   = drawn[VALUE_W-1:0];
              state_next = ST_DONE;
            end else begin
              rem_next   = '0;
              state_next = ST_DIV;
            end
          end
        end
      end
      ST_MUL: begin
        // One multiplier bit per cycle: add the shifted seed where it is set.
        alu_req.a = {1'b0, acc};
        alu_req.b = MIX_MUL[cnt[4:0]] ? {1'b0, sh} : '0;
        acc_next  = alu_sum[WORD_W-1:0];
        sh_next   = {sh[WORD_W-2:0], 1'b0};
        cnt_next  = cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        alu_req.a   = {1'b0, seed};
        alu_req.b   = {1'b0, MIX_ADD};
        word_a_next = nonzero(SEED_A ^ seed);
        word_b_next = nonzero(SEED_B ^ acc);
        word_c_next = nonzero(SEED_C ^ alu_sum[WORD_W-1:0]);
        state_next  = ST_IDLE;
      end
      ST_DIV: begin
        // Restoring step: bring in the next dividend bit, keep the
        // difference when the divisor fits.
        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, trial};
        alu_req.b   = {2'b00, modulus};
        rem_next    = alu_sum[ALU_W-1] ? trial[VALUE_W-1:0] : alu_sum[VALUE_W-1:0];
        dvd_next    = {dvd[WORD_W-2:0], 1'b0};
        cnt_next    = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign div_start = (state == ST_IDLE) && req.valid && (req.operation == OP_DRAW) &&
                     (modulus != '0);
  assign words_nonzero = (word_a != '0) && (word_b != '0) && (word_c != '0);
  assign div_clean = (state == ST_DIV) && (cnt == '0) && (rem == '0);

  `XMD_ASSERT_NOW(a_rem_below_modulus, state == ST_DIV, rem < modulus, "remainder too big")
  `XMD_ASSERT_NEXT(a_reseed_nonzero, state == ST_ADD, words_nonzero, "reseed left a zero word")
  `XMD_ASSERT_NEXT(a_div_start, div_start, div_clean, "divide did not start clean")

endmodule
`default_nettype wire

// ===== src/xorshift_modulo_draw.sv =====
// Top level of the xorshift generator with modulo reduction.
//
//   channel | role   | payload
//   --------+--------+---------------------------------------------
//   req     | sink   | operation (1 bit), seed_value (64 bits)
//   rsp     | source | random_value (63 bits)
//   cfg     | sink   | modulus (63 bits), always ready
//
// A draw steps the generator at the edge that accepts it, then runs 64
// restoring-divide steps through the shared 65-bit adder; the remainder
// then waits in ST_DONE until the output register can take it, and the
// sequencer returns to idle as it moves over. With a zero modulus the
// divide is skipped: the drawn word, cut to 63 bits, goes straight to
// ST_DONE as the result. A reseed runs 32 shift-add steps for the mixing
// multiply and one add of the mixing constant, all on the same adder;
// the words are updated in that add step, which goes back to idle.
// req is ready only while the sequencer is idle. A result waiting in the
// output register does not hold off the next request; only a second
// finished result stalls the sequencer until rsp drains.
// Reset (rst, synchronous) restores the fixed seed words and a modulus of
// 2^32; no clearing pass is needed.
`default_nettype none
module xorshift_modulo_draw
  import xmd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  xmd_req_if.sink  req,
  xmd_rsp_if.source rsp,
  xmd_cfg_if.sink  cfg
);

  logic [VALUE_W-1:0] modulus;
  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic               res_valid;
  logic               res_ready;
  logic [VALUE_W-1:0] res_value;

  // The modulus register takes a write in every cycle.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg.valid) begin
      modulus <= cfg.modulus;
    end
  end

  xmd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .modulus   (modulus),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_value (res_value)
  );

  // The output register loads whenever it is empty or being drained.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_value <= res_value;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.random_value = out_value;

endmodule
`default_nettype wire

// ===== sim/xmd_draw_checker.sv =====
// Checker for the xorshift generator: tracks the generator words and compares drawn values.
`timescale 1ns / 1ps
module xmd_draw_checker
  import xmd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  xmd_req_if   req,
  xmd_rsp_if   rsp,
  xmd_cfg_if   cfg,
  output int   error_count,
  output int   draws_due,
  output int   draws_checked,
  output int   reseeds_seen
);

  logic [WORD_W-1:0]  gen_a;
  logic [WORD_W-1:0]  gen_b;
  logic [WORD_W-1:0]  gen_c;
  logic [VALUE_W-1:0] divisor;
  logic [VALUE_W-1:0] draws_expected[$];

  // Advances the three words by one xorshift step and reduces the new word.
  function automatic logic [VALUE_W-1:0] next_draw();
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] w;
    v = gen_a;
    v = v ^ (v << SHIFT_FIRST);
    v = v ^ (v >> SHIFT_SECOND);
    v = v ^ (v << SHIFT_THIRD);
    gen_a = gen_b;
    gen_b = gen_c;
    gen_c = v ^ gen_a ^ gen_b;
    w = gen_c;
    // A zero divisor leaves the word as it is, cut to the value width.
    if (divisor != '0) begin
      w = w % {1'b0, divisor};
    end
    return w[VALUE_W-1:0];
  endfunction

  function automatic void mix_seed(input logic [WORD_W-1:0] s);
    gen_a = SEED_A ^ s;
    gen_b = SEED_B ^ (s * {{(WORD_W-MUL_BITS){1'b0}}, MIX_MUL});
    gen_c = SEED_C ^ (s + MIX_ADD);
    if (gen_a == '0) begin
      gen_a = WORD_W'(1);
    end
    if (gen_b == '0) begin
      gen_b = WORD_W'(1);
    end
    if (gen_c == '0) begin
      gen_c = WORD_W'(1);
    end
  endfunction

  always @(posedge clk) begin
    logic [VALUE_W-1:0] want;
    if (rst) begin
      gen_a = SEED_A;
      gen_b = SEED_B;
      gen_c = SEED_C;
      divisor = MOD_RESET;
      draws_expected.delete();
      error_count = 0;
      draws_checked = 0;
      reseeds_seen = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        divisor = cfg.modulus;
      end
      if (req.valid && req.ready) begin
        if (xmd_op_t'(req.operation) == OP_RESEED) begin
          mix_seed(req.seed_value);
          reseeds_seen++;
        end else begin
          draws_expected.push_back(next_draw());
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (draws_expected.size() == 0) begin
          $error("random_value: expected nothing, got 0x%h", rsp.random_value);
          error_count++;
        end else begin
          want = draws_expected.pop_front();
          if (rsp.random_value !== want) begin
            $error("random_value: expected 0x%h, got 0x%h", want, rsp.random_value);
            error_count++;
          end
          draws_checked++;
        end
      end
    end
    draws_due = draws_expected.size();
  end

endmodule

// ===== sim/xorshift_modulo_draw_tb.sv =====
// Testbench top for the xorshift generator: stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps
module xorshift_modulo_draw_tb;
  import xmd_pkg::*;

  // Longer than a full draw or reseed inside the block, so this many
  // quiet cycles are enough for the block to finish whatever it started.
  localparam int SETTLE_CYCLES    = 80;
  // The long receiver hold-off, long enough for the block to fill up.
  localparam int LONG_HOLD_CYCLES = 600;
  // Cycles without any handshake before the run is declared hung. The
  // slowest legitimate gap is the long hold-off plus a draw in progress.
  localparam int IDLE_LIMIT       = 4000;
  localparam int PHASES           = 6;
  localparam int ITEMS_PER_PHASE  = 80;

  logic clk = 1'b0;
  logic rst;

  xmd_req_if req ();
  xmd_rsp_if rsp ();
  xmd_cfg_if cfg ();

  int mismatches;
  int draws_due;
  int draws_checked;
  int reseeds_seen;
  int settings_used = 0;
  int idle_cycles = 0;

  // Flow-control knobs for the sender and the receiver; quiet_tail is shared by both.
  logic quiet_tail     = 1'b0;
  logic pressing       = 1'b0;
  logic want_long_hold = 1'b0;
  logic long_hold_done = 1'b0;

  xorshift_modulo_draw uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  xmd_draw_checker draw_check (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rsp           (rsp),
    .cfg           (cfg),
    .error_count   (mismatches),
    .draws_due     (draws_due),
    .draws_checked (draws_checked),
    .reseeds_seen  (reseeds_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: any accepted request, result or register write counts as
  // progress. A long stretch with none of them means the block is stuck.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("xorshift_modulo_draw_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver. Mostly ready, with random stall bursts. Once asked,
  // it holds off for one long stretch so that the output register and the
  // finished result behind it both fill and the request channel stalls.
  // In the tail of the run it never stalls.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (want_long_hold && !long_hold_done) begin
        long_hold_done = 1'b1;
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Offers one request and returns at the edge where it is accepted. Valid
  // stays high afterwards so that back-to-back requests need no gap; this
  // task only lowers it at the start of an idle burst.
  task automatic offer(input xmd_op_t op, input logic [WORD_W-1:0] seed);
    int gap;
    gap = 0;
    if (!quiet_tail && !pressing && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
    end
    if (gap > 0) begin
      req.valid      <= 1'b0;
      req.operation  <= 1'($urandom_range(0, 1));
      req.seed_value <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.operation  <= op;
    req.seed_value <= seed;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // The modulus is only changed with the block idle: every expected draw
  // has come back, and a trailing reseed has had time to finish.
  task automatic write_modulus(input logic [VALUE_W-1:0] m);
    req.valid <= 1'b0;
    do @(posedge clk); while (draws_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg.valid   <= 1'b1;
    cfg.modulus <= m;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [WORD_W-1:0]  mul_inverse;
    logic [WORD_W-1:0]  mul_wide;
    logic [VALUE_W-1:0] m;
    xmd_op_t            op;
    logic [WORD_W-1:0]  seed;

    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.operation  <= OP_DRAW;
    req.seed_value <= '0;
    cfg.valid      <= 1'b0;
    cfg.modulus    <= MOD_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, at the reset modulus of 2^32. The first draws walk
    // the fixed reset words; a draw with a full seed shows that the seed
    // is ignored on a draw.
    offer(OP_DRAW, '0);
    offer(OP_DRAW, '1);
    offer(OP_DRAW, 64'h5555_aaaa_5555_aaaa);

    // Reseeds with the extreme seeds, each followed by a draw.
    offer(OP_RESEED, '0);
    offer(OP_DRAW, '0);
    offer(OP_RESEED, '1);
    offer(OP_DRAW, '0);

    // A seed equal to the first constant clears the first word, which the
    // block must force to one. Two draws carry it through the rotation.
    offer(OP_RESEED, SEED_A);
    offer(OP_DRAW, '0);
    offer(OP_DRAW, '0);

    // A seed that makes the third word's sum equal its constant.
    offer(OP_RESEED, SEED_C - MIX_ADD);
    offer(OP_DRAW, '0);

    // The mixing multiplier is odd, so it has an inverse modulo 2^64;
    // Newton steps double the correct low bits each time. Seeding with the
    // second constant times that inverse clears the second word.
    mul_wide    = {{(WORD_W-MUL_BITS){1'b0}}, MIX_MUL};
    mul_inverse = mul_wide;
    repeat (6) mul_inverse = mul_inverse * (WORD_W'(2) - mul_wide * mul_inverse);
    offer(OP_RESEED, SEED_B * mul_inverse);
    offer(OP_DRAW, '0);

    // Modulus extremes: one gives all zeros, the largest value leaves every
    // word below it as it is, and zero skips the divide altogether.
    write_modulus(VALUE_W'(1));
    offer(OP_DRAW, '0);
    offer(OP_DRAW, '0);
    write_modulus({VALUE_W{1'b1}});
    offer(OP_DRAW, '0);
    offer(OP_DRAW, '0);
    write_modulus('0);
    offer(OP_DRAW, '0);
    offer(OP_DRAW, '0);

    // Random part, one modulus setting per phase. Draws dominate so that
    // long runs of the generator get checked; reseeds come now and then,
    // a few with the seed that clears the first word.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       m = VALUE_W'($urandom_range(2, 1000));
        1:       m = VALUE_W'({$urandom, $urandom});
        2:       m = '0;
        3:       m = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
        4:       m = {VALUE_W{1'b1}} - VALUE_W'($urandom_range(0, 3));
        default: m = VALUE_W'({$urandom, $urandom}) >> $urandom_range(0, 40);
      endcase
      write_modulus(m);

      // In the second phase the receiver stalls for a long stretch while
      // the sender keeps requests coming without gaps.
      if (ph == 1) begin
        pressing       = 1'b1;
        want_long_hold = 1'b1;
      end
      if (ph == PHASES - 1) begin
        quiet_tail = 1'b1;
      end

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 1 && i == ITEMS_PER_PHASE / 2) begin
          pressing = 1'b0;
        end
        op   = ($urandom_range(0, 4) == 0) ? OP_RESEED : OP_DRAW;
        seed = ($urandom_range(0, 15) == 0) ? SEED_A : {$urandom, $urandom};
        offer(op, seed);
      end
    end
    req.valid <= 1'b0;

    // Drain every outstanding draw, then give the block time to show any
    // stray result before the verdict.
    do @(posedge clk); while (draws_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d draws across %0d reseeds and %0d modulus settings,",
             draws_checked, reseeds_seen, settings_used);
    $display("including moduli 0, 1 and 2^63-1 and one %0d-cycle receiver hold-off.",
             LONG_HOLD_CYCLES);
    if (mismatches == 0 && draws_due == 0) begin
      $display("xorshift_modulo_draw_tb: clean");
    end else begin
      $display("xorshift_modulo_draw_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/xmd_pkg.sv
src/xmd_req_if.sv
src/xmd_rsp_if.sv
src/xmd_cfg_if.sv
src/xmd_alu.sv
src/xmd_core.sv
src/xorshift_modulo_draw.sv
sim/xmd_draw_checker.sv
sim/xorshift_modulo_draw_tb.sv
